// ===== rtl/core/gis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gis_pkg;

  localparam int GRP_W = 8;
  localparam int KEY_W = 15;
  localparam int ARR_W = 6;
  localparam int TALLY_W = 7;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  // One stored record: group, key, drop flag, arrival number.
  typedef struct packed {
    logic [GRP_W-1:0] grp;
    logic [KEY_W-1:0] key;
    logic             drop;
    logic [ARR_W-1:0] arr;
  } entry_t;

  // Control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gis_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gis_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gis_pkg::cell_ctl_t ctl,
  input  wire gis_pkg::entry_t   new_e,
  input  wire gis_pkg::entry_t   prev_e,
  input  wire logic              prev_v,
  input  wire gis_pkg::entry_t   next_e,
  input  wire logic              next_v,
  input  wire logic              found_in,
  output logic                   found_out,
  output gis_pkg::entry_t        e,
  output logic                   v
);

  logic hit;

  // The new record goes in front of this slot (an empty slot always matches).
  assign hit = !v || (new_e.grp < e.grp) ||
               ((new_e.grp == e.grp) && (e.drop || (new_e.key < e.key)));
  assign found_out = found_in || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ctl.ins) begin
      if (found_in) begin
        v <= prev_v;
      end else if (hit) begin
        v <= 1'b1;
      end
    end else if (ctl.pop) begin
      v <= next_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (found_in) begin
        e <= prev_e;
      end else if (hit) begin
        e <= new_e;
      end
    end else if (ctl.pop) begin
      e <= next_e;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gis_tally.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gis_tally #(
  parameter int MAX_GROUPS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          inc_en,
  input  wire logic [$clog2(MAX_GROUPS)-1:0] inc_addr,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAX_GROUPS)-1:0] rd_addr,
  output logic [gis_pkg::TALLY_W-1:0]        rd_data,
  input  wire logic                          zero_en,
  input  wire logic [$clog2(MAX_GROUPS)-1:0] zero_addr,
  output logic                               busy
);

  localparam int GW = $clog2(MAX_GROUPS);

  logic [gis_pkg::TALLY_W-1:0] mem [MAX_GROUPS];

  logic [GW-1:0]               sweep_cnt;
  logic                        b_valid;
  logic [GW-1:0]               b_addr;
  logic                        fwd_valid;
  logic [GW-1:0]               fwd_addr;
  logic [gis_pkg::TALLY_W-1:0] fwd_val;
  logic [gis_pkg::TALLY_W-1:0] b_cur;
  logic [gis_pkg::TALLY_W-1:0] b_inc;

  logic                        wr_en;
  logic [GW-1:0]               wr_addr;
  logic [gis_pkg::TALLY_W-1:0] wr_data;
  logic                        rd_any;
  logic [GW-1:0]               rd_sel;

  // Previous cycle's write is not visible in the registered read yet.
  assign b_cur = (fwd_valid && (fwd_addr == b_addr)) ? fwd_val : rd_data;
  assign b_inc = b_cur + gis_pkg::TALLY_W'(1);

  assign rd_any = inc_en || rd_en;
  assign rd_sel = inc_en ? inc_addr : rd_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = zero_addr;
    wr_data = '0;
    if (busy) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt;
    end else if (b_valid) begin
      wr_en   = 1'b1;
      wr_addr = b_addr;
      wr_data = b_inc;
    end else if (zero_en) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_any) begin
      rd_data <= mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      sweep_cnt <= '0;
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (busy) begin
        sweep_cnt <= sweep_cnt + GW'(1);
        if (sweep_cnt == GW'(MAX_GROUPS - 1)) begin
          busy <= 1'b0;
        end
      end
      b_valid   <= inc_en;
      fwd_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_addr   <= inc_addr;
    fwd_addr <= b_addr;
    fwd_val  <= b_inc;
  end

endmodule

`default_nettype wire

// ===== rtl/core/grouped_insertion_sort_index.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Signals              | Beat contents (low bit up)
// s_*     | in  | tvalid tready tdata  | group_number[7:0] sort_key[22:8]
//         |     | tuser tlast          | tuser drop_flag, tlast final_record
// m_*     | out | tvalid tready tdata  | sorted_position, arrival_index, entry_group,
//         |     | tlast                | opens_group, group_tally, capacity_overflow
//
// Load: one record per cycle; all cells compare the record at once and the
// first match plus the shift behind it settle in that cycle.
// A final record is followed by the tally drain state, a pop that loads the fetch
// registers as the tally read is in flight, and the output registers; then one
// result per cycle while m_tready is high as the chain shifts toward its head,
// MAX_RECORDS at most. After reset the group tally memory is swept clear over all
// MAX_GROUPS addresses; s_tready stays low until the sweep ends and ST_CLEAR is left.
// s_tready is low from the final beat until the last result is taken;
// m_tready low stalls the output and fetch registers and the chain shift.
module grouped_insertion_sort_index #(
  parameter int MAX_RECORDS = 64,
  parameter int MAX_GROUPS  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // group_number[7:0], sort_key[22:8], zero
  input  wire logic        s_tuser,   // drop_flag
  input  wire logic        s_tlast,   // final_record
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // sorted_position[5:0], arrival_index[11:6],
                                      // entry_group[19:12], opens_group[20],
                                      // group_tally[27:21], capacity_overflow[28]
  output logic             m_tlast    // final_entry
);

  localparam int GW = $clog2(MAX_GROUPS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  gis_pkg::state_t state;

  logic [CW-1:0] count;
  logic          overflow;
  logic          full;
  logic          s_acc;
  logic          ins;
  logic          in_range_new;
  logic          inc_en;

  gis_pkg::entry_t    new_e;
  gis_pkg::cell_ctl_t ctl;
  gis_pkg::entry_t    e     [MAX_RECORDS];
  logic               v     [MAX_RECORDS];
  logic               found [MAX_RECORDS+1];

  logic                        tally_busy;
  logic [gis_pkg::TALLY_W-1:0] rd_data;
  logic                        zero_en;

  logic                        pop;
  logic                        out_free;
  logic                        f_to_out;
  logic                        head_opens;
  logic [gis_pkg::ARR_W-1:0]   pos;
  logic [gis_pkg::GRP_W-1:0]   prev_grp;

  logic                        f_valid;
  logic [gis_pkg::ARR_W-1:0]   f_pos;
  logic [gis_pkg::ARR_W-1:0]   f_arr;
  logic [gis_pkg::GRP_W-1:0]   f_grp;
  logic                        f_opens;
  logic                        f_last;
  logic                        f_in_range;
  logic [gis_pkg::TALLY_W-1:0] tally_hold;
  logic [gis_pkg::TALLY_W-1:0] tally_val;

  assign full     = (count == CW'(MAX_RECORDS));
  assign s_tready = (state == gis_pkg::ST_LOAD);
  assign s_acc    = s_tvalid && s_tready;
  assign ins      = s_acc && !full;

  assign new_e.grp  = s_tdata[7:0];
  assign new_e.key  = s_tdata[22:8];
  assign new_e.drop = s_tuser;
  assign new_e.arr  = gis_pkg::ARR_W'(count);

  assign in_range_new = (32'(new_e.grp) < MAX_GROUPS);
  assign inc_en       = ins && !s_tuser && in_range_new;

  assign ctl.ins = ins;
  assign ctl.pop = pop;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    gis_pkg::entry_t prev_e;
    gis_pkg::entry_t next_e;
    logic            prev_v;
    logic            next_v;

    if (i == 0) begin : g_first
      assign prev_e = new_e;
      assign prev_v = 1'b0;
    end else begin : g_mid
      assign prev_e = e[i-1];
      assign prev_v = v[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_last
      assign next_e = e[i];
      assign next_v = 1'b0;
    end else begin : g_inner
      assign next_e = e[i+1];
      assign next_v = v[i+1];
    end

    gis_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_e     (new_e),
      .prev_e    (prev_e),
      .prev_v    (prev_v),
      .next_e    (next_e),
      .next_v    (next_v),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .e         (e[i]),
      .v         (v[i])
    );
  end

  // Emission: head cell -> fetch regs (tally read in flight) -> output regs.
  assign out_free   = !m_tvalid || m_tready;
  assign f_to_out   = f_valid && out_free;
  assign pop        = (state == gis_pkg::ST_EMIT) && v[0] && (!f_valid || f_to_out);
  assign head_opens = (pos == '0) || (e[0].grp != prev_grp);
  assign zero_en    = f_to_out && f_opens && f_in_range;

  always_comb begin
    tally_val = '0;
    if (f_in_range) begin
      tally_val = f_opens ? rd_data : tally_hold;
    end
  end

  gis_tally #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .inc_en    (inc_en),
    .inc_addr  (GW'(new_e.grp)),
    .rd_en     (pop),
    .rd_addr   (GW'(e[0].grp)),
    .rd_data   (rd_data),
    .zero_en   (zero_en),
    .zero_addr (GW'(f_grp)),
    .busy      (tally_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gis_pkg::ST_CLEAR;
      count    <= '0;
      overflow <= 1'b0;
      pos      <= '0;
      f_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        gis_pkg::ST_CLEAR: begin
          if (!tally_busy) begin
            state <= gis_pkg::ST_LOAD;
          end
        end
        gis_pkg::ST_LOAD: begin
          if (s_acc) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (s_tlast) begin
              state <= gis_pkg::ST_DRAIN;
            end
          end
        end
        gis_pkg::ST_DRAIN: begin
          state <= gis_pkg::ST_EMIT;
        end
        gis_pkg::ST_EMIT: begin
          if (m_tvalid && m_tready && m_tlast) begin
            state    <= gis_pkg::ST_LOAD;
            count    <= '0;
            overflow <= 1'b0;
            pos      <= '0;
          end else if (pop) begin
            pos <= pos + gis_pkg::ARR_W'(1);
          end
        end
        default: begin
          state <= gis_pkg::ST_CLEAR;
        end
      endcase

      if (pop) begin
        f_valid <= 1'b1;
      end else if (f_to_out) begin
        f_valid <= 1'b0;
      end

      if (f_to_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prev_grp   <= e[0].grp;
      f_pos      <= pos;
      f_arr      <= e[0].arr;
      f_grp      <= e[0].grp;
      f_opens    <= head_opens;
      f_last     <= !v[1];
      f_in_range <= (32'(e[0].grp) < MAX_GROUPS);
    end
    if (f_to_out) begin
      tally_hold <= tally_val;
      m_tdata    <= {3'b000, overflow, tally_val, f_opens, f_grp, f_arr, f_pos};
      m_tlast    <= f_last;
    end
  end

endmodule

`default_nettype wire
